[design/pomask_pkg.sv]
// Package for the packed opacity mask store.
// Holds the shared widths, register indexes, codes and the result record.
// No dependencies.
package pomask_pkg;

    localparam int MASK_ENTRIES = 65536;

    localparam int COORD_W    = 24;
    localparam int COUNT_W    = 17;
    localparam int CODE_W     = 2;
    localparam int PROD_W     = COORD_W + COUNT_W;
    localparam int POS_W      = PROD_W + 1;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        REG_START_ROW = 2'd0,
        REG_START_COL = 2'd1,
        REG_ROW_COUNT = 2'd2,
        REG_COL_COUNT = 2'd3
    } reg_idx_t;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 2'd0;

    typedef struct packed {
        logic [CODE_W-1:0] opacity;
        logic              in_region;
    } result_t;

endpackage

[design/packed_opacity_mask_store.sv]
// Top level of the packed opacity mask store.
// Instantiates pomask_front, pomask_back and two pomask_fifo queues; uses pomask_pkg.
//
// A map of 2-bit opacity codes over a rectangular tile region. The region is set
// through the APB port (start_row, start_col, row_count, col_count at byte offsets
// 0, 4, 8 and 12); the user must do so only while the block is idle, which the block
// does not enforce. Items enter as a queue: a beat is taken when push is high and
// full is low. Each item is a read or a write of one code at (row, col) and gives
// exactly one result beat, taken when pop is high and empty low. Results keep the
// order of the items. An item passes the front stages, the command queue, the
// pending record and the result queue on its way to the ports. One item is taken
// per cycle while results are taken without stalls: the front stages, the command
// queue and the store RAM each handle one beat a cycle, and the RAM port does one
// read or one write per item. After reset the store is swept to zero, one entry a
// cycle; full stays high during the sweep, while the configuration port works as
// usual. When the receiver stalls, up to four results wait in the result queue,
// then the command queue and front stages fill and full rises.
module packed_opacity_mask_store #(
    parameter int MASK_ENTRIES = pomask_pkg::MASK_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pomask_pkg::PADDR_W-1:0]  paddr,
    input  logic [pomask_pkg::PDATA_W-1:0]  pwdata,
    output logic [pomask_pkg::PDATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            push,
    output logic                            full,
    input  logic                            func,
    input  logic [pomask_pkg::COORD_W-1:0]  row,
    input  logic [pomask_pkg::COORD_W-1:0]  col,
    input  logic [pomask_pkg::CODE_W-1:0]   write_value,
    output logic                            empty,
    input  logic                            pop,
    output logic [pomask_pkg::CODE_W-1:0]   opacity,
    output logic                            in_region
);

    localparam int AW    = $clog2(MASK_ENTRIES);
    localparam int CMD_W = AW + pomask_pkg::CODE_W + 2;
    localparam int RES_W = $bits(pomask_pkg::result_t);

    logic                              clearing;
    logic                              cmd_push;
    logic                              cmd_full;
    logic                              cmd_hit_in;
    logic                              cmd_write_in;
    logic [pomask_pkg::CODE_W-1:0]     cmd_value_in;
    logic [AW-1:0]                     cmd_addr_in;
    logic [CMD_W-1:0]                  cmd_wdata;
    logic [CMD_W-1:0]                  cmd_rdata;
    logic                              cmd_empty;
    logic                              cmd_pop;
    logic [pomask_pkg::FIFO_CNT_W-1:0] cmd_count;

    logic                              out_push;
    pomask_pkg::result_t               out_wdata;
    pomask_pkg::result_t               out_rdata;
    logic                              out_full;
    logic [pomask_pkg::FIFO_CNT_W-1:0] out_count;

    assign pready = 1'b1;

    pomask_front #(
        .MASK_ENTRIES (MASK_ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .push        (push),
        .full        (full),
        .func        (func),
        .row         (row),
        .col         (col),
        .write_value (write_value),
        .clearing    (clearing),
        .cmd_push    (cmd_push),
        .cmd_full    (cmd_full),
        .cmd_hit     (cmd_hit_in),
        .cmd_write   (cmd_write_in),
        .cmd_value   (cmd_value_in),
        .cmd_addr    (cmd_addr_in)
    );

    assign cmd_wdata = {cmd_hit_in, cmd_write_in, cmd_value_in, cmd_addr_in};

    pomask_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (pomask_pkg::FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty),
        .full  (cmd_full),
        .count (cmd_count)
    );

    pomask_back #(
        .MASK_ENTRIES (MASK_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .cmd_empty (cmd_empty || (cmd_count == '0)),
        .cmd_pop   (cmd_pop),
        .cmd_hit   (cmd_rdata[CMD_W-1]),
        .cmd_write (cmd_rdata[CMD_W-2]),
        .cmd_value (cmd_rdata[AW+pomask_pkg::CODE_W-1:AW]),
        .cmd_addr  (cmd_rdata[AW-1:0]),
        .out_count (out_count),
        .out_push  (out_push),
        .out_data  (out_wdata)
    );

    pomask_fifo #(
        .WIDTH (RES_W),
        .DEPTH (pomask_pkg::FIFO_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push && !out_full),
        .wdata (out_wdata),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .full  (out_full),
        .count (out_count)
    );

    assign opacity   = out_rdata.opacity;
    assign in_region = out_rdata.in_region;

endmodule

[design/pomask_ram.sv]
// Generic single-port RAM with a registered read port.
// Used for the opacity code store. No dependencies.
module pomask_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[design/pomask_fifo.sv]
// Small register FIFO used between the front and back parts and on the result side.
// No package dependencies.
module pomask_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[design/pomask_front.sv]
// Front part: configuration registers, input acceptance and region classification.
// Two stages turn a coordinate into a hit flag and a store address. Uses pomask_pkg.
module pomask_front #(
    parameter int MASK_ENTRIES = pomask_pkg::MASK_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pomask_pkg::PADDR_W-1:0]     paddr,
    input  logic [pomask_pkg::PDATA_W-1:0]     pwdata,
    output logic [pomask_pkg::PDATA_W-1:0]     prdata,
    input  logic                               push,
    output logic                               full,
    input  logic                               func,
    input  logic [pomask_pkg::COORD_W-1:0]     row,
    input  logic [pomask_pkg::COORD_W-1:0]     col,
    input  logic [pomask_pkg::CODE_W-1:0]      write_value,
    input  logic                               clearing,
    output logic                               cmd_push,
    input  logic                               cmd_full,
    output logic                               cmd_hit,
    output logic                               cmd_write,
    output logic [pomask_pkg::CODE_W-1:0]      cmd_value,
    output logic [$clog2(MASK_ENTRIES)-1:0]    cmd_addr
);

    localparam int AW = $clog2(MASK_ENTRIES);
    localparam logic [pomask_pkg::POS_W-1:0] POS_LIMIT = pomask_pkg::POS_W'(MASK_ENTRIES);

    logic [pomask_pkg::COORD_W-1:0] start_row_reg;
    logic [pomask_pkg::COORD_W-1:0] start_col_reg;
    logic [pomask_pkg::COUNT_W-1:0] row_count_reg;
    logic [pomask_pkg::COUNT_W-1:0] col_count_reg;
    logic                           cfg_write;
    pomask_pkg::reg_idx_t           reg_idx;

    logic [pomask_pkg::COORD_W-1:0] drow;
    logic [pomask_pkg::COORD_W-1:0] dcol;
    logic                           in_bounds;
    logic                           accept;
    logic                           s1_ready;
    logic                           s2_ready;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic                           s1_inside_reg;
    logic                           s1_write_reg;
    logic [pomask_pkg::CODE_W-1:0]  s1_value_reg;
    logic [pomask_pkg::COORD_W-1:0] s1_drow_reg;
    logic [pomask_pkg::COUNT_W-1:0] s1_dcol_reg;

    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    logic                           s2_inside_reg;
    logic                           s2_write_reg;
    logic [pomask_pkg::CODE_W-1:0]  s2_value_reg;
    logic [pomask_pkg::PROD_W-1:0]  s2_prod_reg;
    logic [pomask_pkg::COUNT_W-1:0] s2_dcol_reg;
    logic [pomask_pkg::POS_W-1:0]   s2_pos;

    // Configuration port.
    assign reg_idx   = pomask_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= '0;
            start_col_reg <= '0;
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                pomask_pkg::REG_START_ROW: start_row_reg <= pwdata[pomask_pkg::COORD_W-1:0];
                pomask_pkg::REG_START_COL: start_col_reg <= pwdata[pomask_pkg::COORD_W-1:0];
                pomask_pkg::REG_ROW_COUNT: row_count_reg <= pwdata[pomask_pkg::COUNT_W-1:0];
                pomask_pkg::REG_COL_COUNT: col_count_reg <= pwdata[pomask_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pomask_pkg::REG_START_ROW: prdata = pomask_pkg::PDATA_W'(start_row_reg);
            pomask_pkg::REG_START_COL: prdata = pomask_pkg::PDATA_W'(start_col_reg);
            pomask_pkg::REG_ROW_COUNT: prdata = pomask_pkg::PDATA_W'(row_count_reg);
            pomask_pkg::REG_COL_COUNT: prdata = pomask_pkg::PDATA_W'(col_count_reg);
            default:                   prdata = '0;
        endcase
    end

    // Pipeline flow control: each stage moves when the one after it has room.
    assign s2_ready = !s2_valid_reg || !cmd_full;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign full     = clearing || !s1_ready;
    assign accept   = push && !full;
    assign cmd_push = s2_valid_reg && !cmd_full;

    // Stage one: offsets from the region origin and the bounds check.
    assign drow      = row - start_row_reg;
    assign dcol      = col - start_col_reg;
    assign in_bounds = (row >= start_row_reg) && (col >= start_col_reg)
                    && (drow < pomask_pkg::COORD_W'(row_count_reg))
                    && (dcol < pomask_pkg::COORD_W'(col_count_reg));

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_ready)
        begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s2_valid_reg;
        if (s1_valid_reg && s2_ready)
        begin
            s2_valid_next = 1'b1;
        end
        else if (cmd_push)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_inside_reg <= in_bounds;
            s1_write_reg  <= (func == pomask_pkg::FUNC_WRITE);
            s1_value_reg  <= write_value;
            s1_drow_reg   <= drow;
            s1_dcol_reg   <= dcol[pomask_pkg::COUNT_W-1:0];
        end
        // Stage two: the row offset times the row stride.
        if (s1_valid_reg && s2_ready)
        begin
            s2_inside_reg <= s1_inside_reg;
            s2_write_reg  <= s1_write_reg;
            s2_value_reg  <= s1_value_reg;
            s2_prod_reg   <= pomask_pkg::PROD_W'(s1_drow_reg)
                           * pomask_pkg::PROD_W'(col_count_reg);
            s2_dcol_reg   <= s1_dcol_reg;
        end
    end

    // The position is formed without wrap, so the store bound catches large regions.
    assign s2_pos    = pomask_pkg::POS_W'(s2_prod_reg) + pomask_pkg::POS_W'(s2_dcol_reg);
    assign cmd_hit   = s2_inside_reg && (s2_pos < POS_LIMIT);
    assign cmd_write = s2_write_reg;
    assign cmd_value = s2_value_reg;
    assign cmd_addr  = s2_pos[AW-1:0];

endmodule

[design/pomask_back.sv]
// Back part: clears the code store after reset, then carries out reads and writes.
// Drives the store RAM and the result queue. Uses pomask_pkg and pomask_ram.
module pomask_back #(
    parameter int MASK_ENTRIES = pomask_pkg::MASK_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    output logic                                clearing,
    input  logic                                cmd_empty,
    output logic                                cmd_pop,
    input  logic                                cmd_hit,
    input  logic                                cmd_write,
    input  logic [pomask_pkg::CODE_W-1:0]       cmd_value,
    input  logic [$clog2(MASK_ENTRIES)-1:0]     cmd_addr,
    input  logic [pomask_pkg::FIFO_CNT_W-1:0]   out_count,
    output logic                                out_push,
    output pomask_pkg::result_t                 out_data
);

    localparam int AW  = $clog2(MASK_ENTRIES);
    localparam int SCW = pomask_pkg::FIFO_CNT_W + 1;

    logic                          clearing_reg;
    logic                          clearing_next;
    logic [AW-1:0]                 clr_addr_reg;
    logic [AW-1:0]                 clr_addr_next;

    logic                          issue;
    logic [SCW-1:0]                slots_used;

    logic                          ram_we;
    logic [AW-1:0]                 ram_addr;
    logic [pomask_pkg::CODE_W-1:0] ram_wdata;
    logic [pomask_pkg::CODE_W-1:0] ram_rdata;

    logic                          pend_valid_reg;
    logic                          pend_read_reg;
    logic                          pend_hit_reg;
    logic [pomask_pkg::CODE_W-1:0] pend_code_reg;

    // One entry a cycle is zeroed until the whole store has been swept.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(MASK_ENTRIES - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    // A command issues only when the result queue has room for it and the one in flight.
    assign slots_used = SCW'(out_count) + SCW'(pend_valid_reg);
    assign issue      = !clearing_reg && !cmd_empty
                     && (slots_used < SCW'(pomask_pkg::FIFO_DEPTH));
    assign cmd_pop    = issue;
    assign clearing   = clearing_reg;

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = pomask_pkg::CODE_UNKNOWN;
        end
        else
        begin
            ram_we    = issue && cmd_hit && cmd_write;
            ram_addr  = cmd_addr;
            ram_wdata = cmd_value;
        end
    end

    pomask_ram #(
        .WIDTH (pomask_pkg::CODE_W),
        .DEPTH (MASK_ENTRIES)
    ) u_store (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clr_addr_reg   <= clr_addr_next;
            pend_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_read_reg <= cmd_hit && !cmd_write;
            pend_hit_reg  <= cmd_hit;
            pend_code_reg <= (cmd_hit && cmd_write) ? cmd_value : pomask_pkg::CODE_UNKNOWN;
        end
    end

    // The read data arrives in the cycle after issue, together with the pending record.
    assign out_push           = pend_valid_reg;
    assign out_data.opacity   = pend_read_reg ? ram_rdata : pend_code_reg;
    assign out_data.in_region = pend_hit_reg;

endmodule

[design/pomask_checker.sv]
// Port-level checker for the packed opacity mask store, bound to the top level.
// Depends on pomask_pkg for widths and codes.
module pomask_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            push,
    input logic                            full,
    input logic                            empty,
    input logic                            pop,
    input logic [pomask_pkg::CODE_W-1:0]   opacity,
    input logic                            in_region
);

    logic [4:0] outstanding_reg;
    logic [4:0] outstanding_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = push && !full;
    assign out_beat = pop && !empty;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_beat && !out_beat)
        begin
            outstanding_next = outstanding_reg + 5'd1;
        end
        else if (out_beat && !in_beat)
        begin
            outstanding_next = outstanding_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A result may only be shown for an item that was taken and not yet answered.
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outstanding_reg != 5'd0))
        else $error("result shown with no item outstanding");

    // A miss never carries a stored code.
    a_miss_is_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !in_region) |-> (opacity == pomask_pkg::CODE_UNKNOWN))
        else $error("out-of-region result carries a nonzero code");

    // A waiting result stays put until it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(opacity) && $stable(in_region)))
        else $error("waiting result changed or vanished");

endmodule

bind packed_opacity_mask_store pomask_checker u_pomask_checker (.*);

[tb/packed_opacity_mask_store_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for packed_opacity_mask_store: directed table, then random phases.
// Keeps its own mirror of the 2-bit opacity map and the region registers to predict each beat.
// Depends on pomask_pkg and the packed_opacity_mask_store RTL.
module packed_opacity_mask_store_test;

    typedef enum logic {
        STEP_CFG  = 1'b0,
        STEP_ITEM = 1'b1
    } step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        pomask_pkg::reg_idx_t  sel;
        logic [31:0]           value;
        logic                  func;
        logic [23:0]           row;
        logic [23:0]           col;
        logic [1:0]            code;
        logic                  typed;
        logic [1:0]            want_opacity;
        logic                  want_hit;
    } step_t;

    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 195;
    localparam int HOLD_CYCLES    = 300;

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [pomask_pkg::PADDR_W-1:0]   paddr;
    logic [pomask_pkg::PDATA_W-1:0]   pwdata;
    logic [pomask_pkg::PDATA_W-1:0]   prdata;
    logic                             pready;
    logic                             push;
    logic                             full;
    logic                             func;
    logic [pomask_pkg::COORD_W-1:0]   row;
    logic [pomask_pkg::COORD_W-1:0]   col;
    logic [pomask_pkg::CODE_W-1:0]    write_value;
    logic                             empty;
    logic                             pop;
    logic [pomask_pkg::CODE_W-1:0]    opacity;
    logic                             in_region;

    // Mirror of the block: the opacity map and the region registers.
    logic [1:0]           mask_mirror [0:pomask_pkg::MASK_ENTRIES-1];
    logic [23:0]          cfg_start_row;
    logic [23:0]          cfg_start_col;
    logic [16:0]          cfg_rows;
    logic [16:0]          cfg_cols;

    pomask_pkg::result_t  opacity_due[$];
    logic [47:0]          recent_spots[$];
    int                   errors = 0;
    int                   n_items = 0;
    int                   n_hits = 0;
    int                   n_writes = 0;
    int                   n_settings = 0;
    bit                   calm = 1'b0;
    bit                   hold_pop = 1'b0;

    step_t directed_steps[$] = '{
        // The region is empty after reset, so everything misses.
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_WRITE,
          24'h0, 24'h0, 2'd3, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_START_ROW, 32'h10, pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_START_COL, 32'h20, pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_ROW_COUNT, 32'd3,  pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_COL_COUNT, 32'd5,  pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_WRITE,
          24'h10, 24'h20, 2'd3, 1'b1, 2'd3, 1'b1},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h10, 24'h20, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_WRITE,
          24'h12, 24'h24, 2'd2, 1'b1, 2'd2, 1'b1},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h12, 24'h24, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h0f, 24'h20, 2'd0, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h10, 24'h1f, 2'd0, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h13, 24'h20, 2'd0, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h10, 24'h25, 2'd0, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_WRITE,
          24'h13, 24'h25, 2'd1, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        // A write to the neighbor in the next column must not disturb the first entry.
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_WRITE,
          24'h10, 24'h21, 2'd1, 1'b1, 2'd1, 1'b1},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h10, 24'h20, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_WRITE,
          24'h10, 24'h20, 2'd0, 1'b1, 2'd0, 1'b1},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'hffffff, 24'hffffff, 2'd0, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_START_ROW, 32'hffffff, pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_START_COL, 32'hffffff, pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_ROW_COUNT, 32'h10000,  pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_COL_COUNT, 32'h10000,  pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_WRITE,
          24'hffffff, 24'hffffff, 2'd2, 1'b1, 2'd2, 1'b1},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'hffffff, 24'hffffff, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_CFG,  pomask_pkg::REG_START_COL, 32'd0, pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0},
        // Full 65536 x 65536 region at the origin: the second row is past the store.
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h0, 24'hffff, 2'd0, 1'b0, 2'd0, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_WRITE,
          24'h0, 24'hffff, 2'd3, 1'b1, 2'd3, 1'b1},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h1, 24'h0, 2'd0, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_WRITE,
          24'h1, 24'h0, 2'd1, 1'b1, pomask_pkg::CODE_UNKNOWN, 1'b0},
        '{STEP_ITEM, pomask_pkg::REG_START_ROW, 32'd0, pomask_pkg::FUNC_READ,
          24'h0, 24'h0, 2'd0, 1'b0, 2'd0, 1'b0}
    };

    packed_opacity_mask_store dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .func        (func),
        .row         (row),
        .col         (col),
        .write_value (write_value),
        .empty       (empty),
        .pop         (pop),
        .opacity     (opacity),
        .in_region   (in_region)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("packed_opacity_mask_store_test NOT OK");
        $finish;
    end

    // Predicts one access and applies a write to the mirror.
    function automatic pomask_pkg::result_t apply_access(input logic f, input logic [23:0] r,
                                                         input logic [23:0] c,
                                                         input logic [1:0] v);
        pomask_pkg::result_t res;
        logic [63:0]         dr;
        logic [63:0]         dc;
        logic [63:0]         p;
        res.opacity   = pomask_pkg::CODE_UNKNOWN;
        res.in_region = 1'b0;
        if (r >= cfg_start_row && c >= cfg_start_col)
        begin
            dr = 64'(r) - 64'(cfg_start_row);
            dc = 64'(c) - 64'(cfg_start_col);
            if (dr < 64'(cfg_rows) && dc < 64'(cfg_cols))
            begin
                p = dr * 64'(cfg_cols) + dc;
                if (p < 64'(pomask_pkg::MASK_ENTRIES))
                begin
                    res.in_region = 1'b1;
                    if (f == pomask_pkg::FUNC_WRITE)
                    begin
                        mask_mirror[p[15:0]] = v;
                        res.opacity = v;
                    end
                    else
                    begin
                        res.opacity = mask_mirror[p[15:0]];
                    end
                end
            end
        end
        return res;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // One of the four coordinates around a region boundary on one axis.
    function automatic logic [23:0] edge_coord(input logic [23:0] start, input logic [16:0] cnt);
        logic [23:0] last;
        last = start + 24'(cnt);
        case ($urandom_range(0, 3))
            0:       return start - 24'd1;
            1:       return start;
            2:       return last - 24'd1;
            default: return last;
        endcase
    endfunction

    task automatic offer_item(input logic f, input logic [23:0] r, input logic [23:0] c,
                              input logic [1:0] v, input logic typed,
                              input pomask_pkg::result_t want);
        pomask_pkg::result_t predicted;
        @(negedge clk);
        push        <= 1'b1;
        func        <= f;
        row         <= r;
        col         <= c;
        write_value <= v;
        do
            @(posedge clk);
        while (full !== 1'b0);
        predicted = apply_access(f, r, c, v);
        opacity_due.push_back(typed ? want : predicted);
        recent_spots.push_back({r, c});
        if (recent_spots.size() > 16)
            void'(recent_spots.pop_front());
        n_items++;
        if (predicted.in_region)
            n_hits++;
        if (f == pomask_pkg::FUNC_WRITE)
            n_writes++;
    endtask

    task automatic sender_gap(input int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Writes one region register once all results are in, then reads it back.
    task automatic program_reg(input pomask_pkg::reg_idx_t sel, input logic [31:0] value);
        logic [31:0] keep;
        keep = (sel == pomask_pkg::REG_ROW_COUNT || sel == pomask_pkg::REG_COL_COUNT)
             ? 32'h1ffff : 32'hffffff;
        @(negedge clk);
        push <= 1'b0;
        while (opacity_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (sel)
            pomask_pkg::REG_START_ROW: cfg_start_row = value[23:0];
            pomask_pkg::REG_START_COL: cfg_start_col = value[23:0];
            pomask_pkg::REG_ROW_COUNT: cfg_rows      = value[16:0];
            default:                   cfg_cols      = value[16:0];
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if ((prdata & keep) !== (value & keep))
        begin
            $error("prdata: expected %0h, actual %0h", value & keep, prdata & keep);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int unsigned stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pop)
            begin
                hold_pop = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                    pop <= 1'b1;
                else
                begin
                    pop <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        pomask_pkg::result_t want;
        if (rst_n && empty === 1'b0 && pop)
        begin
            if (opacity_due.size() == 0)
            begin
                $error("unexpected result beat: opacity %0d, in_region %0d", opacity, in_region);
                errors++;
            end
            else
            begin
                want = opacity_due.pop_front();
                if (opacity !== want.opacity)
                begin
                    $error("opacity: expected %0d, actual %0d", want.opacity, opacity);
                    errors++;
                end
                if (in_region !== want.in_region)
                begin
                    $error("in_region: expected %0d, actual %0d", want.in_region, in_region);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        step_t                cur_step;
        pomask_pkg::result_t  want;
        logic                 f;
        logic [23:0]          r;
        logic [23:0]          c;
        logic [47:0]          spot;
        logic [23:0]          sr;
        logic [23:0]          sc;
        logic [16:0]          rc;
        logic [16:0]          cc;
        logic [63:0]          span;
        logic [63:0]          lim;
        logic [63:0]          p;
        int unsigned          pick;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        push        = 1'b0;
        func        = pomask_pkg::FUNC_READ;
        row         = '0;
        col         = '0;
        write_value = '0;
        cfg_start_row = '0;
        cfg_start_col = '0;
        cfg_rows      = '0;
        cfg_cols      = '0;
        foreach (mask_mirror[i])
            mask_mirror[i] = 2'd0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            cur_step = directed_steps[i];
            if (cur_step.kind == STEP_CFG)
                program_reg(cur_step.sel, cur_step.value);
            else
            begin
                want.opacity   = cur_step.want_opacity;
                want.in_region = cur_step.want_hit;
                offer_item(cur_step.func, cur_step.row, cur_step.col, cur_step.code,
                           cur_step.typed, want);
                sender_gap(pick_gap());
            end
        end
        n_settings = 4;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            sr = 24'($urandom);
            sc = 24'($urandom);
            case (phase)
                0: begin rc = 17'd8; cc = 17'd8; end
                1: begin sr = '0; sc = '0; rc = 17'd256; cc = 17'd256; end
                2: begin rc = 17'd0; cc = 17'($urandom_range(1, 65536)); end
                3: begin sr = 24'hffffff - 24'($urandom_range(0, 255));
                         rc = 17'h10000; cc = 17'h10000; end
                4: begin rc = 17'h10000; cc = 17'd1; end
                5: begin rc = 17'h10000; cc = 17'd0; end
                6: begin rc = 17'($urandom_range(1, 65536)); cc = 17'($urandom_range(1, 65536)); end
                7: begin sr = 24'hffffff; sc = 24'hffffff; rc = 17'd1; cc = 17'd1; end
                8: begin rc = 17'($urandom_range(1, 16)); cc = 17'($urandom_range(1, 4096)); end
                default: begin rc = 17'd3; cc = 17'd5; end
            endcase
            program_reg(pomask_pkg::REG_START_ROW, 32'(sr));
            program_reg(pomask_pkg::REG_START_COL, 32'(sc));
            program_reg(pomask_pkg::REG_ROW_COUNT, 32'(rc));
            program_reg(pomask_pkg::REG_COL_COUNT, 32'(cc));
            n_settings++;
            // Stop draining results for a while so the block fills and pushes back.
            if (phase == 1 || phase == 6)
                hold_pop = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 30 && recent_spots.size() != 0)
                begin
                    spot = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
                    r = spot[47:24];
                    c = spot[23:0];
                end
                else if (pick < 75 && cfg_rows != 0 && cfg_cols != 0)
                begin
                    // Pick a position near or inside the store, a few just past its end.
                    span = 64'(cfg_rows) * 64'(cfg_cols);
                    lim  = (span < 64'(pomask_pkg::MASK_ENTRIES + 8))
                         ? span : 64'(pomask_pkg::MASK_ENTRIES + 8);
                    p    = 64'($urandom_range(0, 32'(lim - 1)));
                    r    = cfg_start_row + 24'(p / 64'(cfg_cols));
                    c    = cfg_start_col + 24'(p % 64'(cfg_cols));
                end
                else if (pick < 88)
                begin
                    r = edge_coord(cfg_start_row, cfg_rows);
                    c = edge_coord(cfg_start_col, cfg_cols);
                end
                else
                begin
                    r = 24'($urandom);
                    c = 24'($urandom);
                end
                f = ($urandom_range(0, 1) == 1) ? pomask_pkg::FUNC_WRITE : pomask_pkg::FUNC_READ;
                want = '0;
                offer_item(f, r, c, 2'($urandom), 1'b0, want);
                sender_gap(pick_gap());
            end
        end

        calm = 1'b0;
        @(negedge clk);
        push <= 1'b0;
        while (opacity_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d accesses, %0d writes, %0d inside the region and store,",
                 n_items, n_writes, n_hits);
        $display("over %0d region settings including empty, full-size and top-corner regions.",
                 n_settings);
        if (errors == 0)
            $display("packed_opacity_mask_store_test OK");
        else
            $display("packed_opacity_mask_store_test NOT OK");
        $finish;
    end

endmodule

[packed_opacity_mask_store.f]
design/pomask_pkg.sv
design/pomask_ram.sv
design/pomask_fifo.sv
design/pomask_front.sv
design/pomask_back.sv
design/packed_opacity_mask_store.sv
design/pomask_checker.sv
tb/packed_opacity_mask_store_test.sv
